### hw/rtl/flf_pkg.sv
// ----------------------------------------------------------------------------
// Spliced flank locator package
// Shared widths, codes, payload layouts and the item types passed between the
// front end and the exon engine.
// ----------------------------------------------------------------------------
package flf_pkg;

   // Field widths
   localparam int COORD_W  = 31;
   localparam int INDEX_W  = 9;
   localparam int NUM_W    = 10;
   localparam int FLANK_W  = 16;
   localparam int COUNT_W  = 10;

   // Table size default
   localparam int MAX_EXONS_DEF = 512;

   // Front end queue, depth is a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // Stream payload widths
   localparam int REQ_DATA_W = 104;
   localparam int REQ_PAD_W  = REQ_DATA_W - INDEX_W - 3 * COORD_W;
   localparam int RSP_DATA_W = 72;

   // Configuration port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_FLANK_SIZE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXON_COUNT = 8'd1;
   localparam logic [FLANK_W-1:0]   FLANK_RESET    = 16'd20;
   localparam logic [COUNT_W-1:0]   COUNT_RESET    = 10'd1;

   // Request op codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Result status codes
   localparam logic STATUS_FOUND = 1'b0;
   localparam logic STATUS_MISS  = 1'b1;

   typedef enum logic {
      CMD_LOAD,
      CMD_QUERY
   } cmd_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_BACK,
      ST_FWD,
      ST_EMIT
   } eng_state_type;

   // Request payload, last field in the lowest bits
   typedef struct packed {
      logic [REQ_PAD_W-1:0] pad;
      logic [COORD_W-1:0]   position;
      logic [COORD_W-1:0]   exon_end;
      logic [COORD_W-1:0]   exon_start;
      logic [INDEX_W-1:0]   exon_index;
   } req_payload_type;

   // Result payload, last field in the lowest bits
   typedef struct packed {
      logic [COORD_W-1:0] flank_end;
      logic [COORD_W-1:0] flank_start;
      logic [NUM_W-1:0]   exon_number;
   } rsp_payload_type;

   // Classified item, front end to engine
   typedef struct packed {
      cmd_kind_type       kind;
      logic [INDEX_W-1:0] index;
      logic [COORD_W-1:0] coord_a;   // load: start, query: position
      logic [COORD_W-1:0] coord_b;   // load: end
   } cmd_type;

   typedef struct packed {
      logic               status;
      logic [NUM_W-1:0]   exon_number;
      logic [COORD_W-1:0] flank_start;
      logic [COORD_W-1:0] flank_end;
   } res_type;

   typedef struct packed {
      logic [FLANK_W-1:0] flank_size;
      logic [COUNT_W-1:0] exon_count;
   } cfg_type;

endpackage

### hw/rtl/spliced_flank_locator.sv
// ----------------------------------------------------------------------------
// Spliced flank locator
// Exon table of one gene with spliced flank bound lookup for query positions.
// ----------------------------------------------------------------------------
// Load item: held in the front queue, then written to the exon tables when the
//   engine is idle; the engine retires one load per cycle while idle.
// Query item: the engine scans the exons for the one holding the position,
//   walks backward and then forward from that exon for the flank bounds and
//   emits the result; the single read port of the exon tables reads one entry
//   per cycle. The engine stays busy until the result is emitted.
// One item is worked at a time; the two-entry front queue takes new items
//   meanwhile. Reset clears control state, flank_size to 20, exon_count to 1;
//   the exon tables hold nothing defined until loaded.
// ----------------------------------------------------------------------------
module spliced_flank_locator #(
   parameter int MAX_EXONS = flf_pkg::MAX_EXONS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // exon_index[8:0], exon_start[39:9], exon_end[70:40], position[101:71]
   input  logic [flf_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op[0]
   input  logic                              req_tuser,
   // Result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // exon_number[9:0], flank_start[40:10], flank_end[71:41]
   output logic [flf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status[0]
   output logic                              rsp_tuser,
   // Configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [flf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [flf_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic [flf_pkg::FLANK_W-1:0]  flank_size_ff, flank_size_in;
   logic [flf_pkg::COUNT_W-1:0]  exon_count_ff, exon_count_in;
   flf_pkg::cfg_type             cfg;
   logic                         q_valid;
   flf_pkg::cmd_type             q_cmd;
   logic                         q_pop;
   logic                         res_valid;
   flf_pkg::res_type             res;
   flf_pkg::rsp_payload_type     rsp_fields;

   // Registers take writes at any time; unknown indexes drop silently
   assign csr_ready = 1'b1;

   always_comb begin
      flank_size_in = flank_size_ff;
      exon_count_in = exon_count_ff;
      if (csr_valid) begin
         unique case (csr_index)
            flf_pkg::CSR_FLANK_SIZE: flank_size_in = csr_data;
            flf_pkg::CSR_EXON_COUNT: exon_count_in = csr_data[flf_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flank_size_ff <= flf_pkg::FLANK_RESET;
         exon_count_ff <= flf_pkg::COUNT_RESET;
      end else begin
         flank_size_ff <= flank_size_in;
         exon_count_ff <= exon_count_in;
      end
   end

   assign cfg.flank_size = flank_size_ff;
   assign cfg.exon_count = exon_count_ff;

   // Front end: accept, classify, queue
   flf_front #(
      .MAX_EXONS (MAX_EXONS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop)
   );

   // Back end: tables, scan, walks, result register
   flf_engine #(
      .MAX_EXONS (MAX_EXONS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_valid (res_valid),
      .rsp_res   (res),
      .rsp_ready (rsp_tready)
   );

   // Pack the result item onto the stream
   always_comb begin
      rsp_fields.exon_number = res.exon_number;
      rsp_fields.flank_start = res.flank_start;
      rsp_fields.flank_end   = res.flank_end;
   end

   assign rsp_tvalid = res_valid;
   assign rsp_tdata  = flf_pkg::RSP_DATA_W'(rsp_fields);
   assign rsp_tuser  = res.status;

endmodule

### hw/rtl/flf_front.sv
// ----------------------------------------------------------------------------
// Spliced flank locator front end
// Accepts request items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module flf_front #(
   parameter int MAX_EXONS = flf_pkg::MAX_EXONS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [flf_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               req_tuser,
   output logic                               q_valid,
   output flf_pkg::cmd_type                   q_cmd,
   input  logic                               q_pop
);

   flf_pkg::cmd_type                      queue_ff [flf_pkg::QUEUE_DEPTH];
   logic [flf_pkg::QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [flf_pkg::QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [flf_pkg::QUEUE_CNT_W-1:0]       count_ff, count_in;
   flf_pkg::req_payload_type              req_fields;
   flf_pkg::cmd_type                      cmd_new;
   logic                                  keep;
   logic                                  push;

   assign req_fields = flf_pkg::req_payload_type'(req_tdata);
   assign req_tready = count_ff != flf_pkg::QUEUE_CNT_W'(flf_pkg::QUEUE_DEPTH);

   // Drop loads aimed beyond the table
   assign keep = (req_tuser == flf_pkg::OP_QUERY) ||
                 (32'(req_fields.exon_index) < MAX_EXONS);
   assign push = req_tvalid && req_tready && keep;

   always_comb begin
      cmd_new.kind    = (req_tuser == flf_pkg::OP_QUERY) ? flf_pkg::CMD_QUERY
                                                          : flf_pkg::CMD_LOAD;
      cmd_new.index   = req_fields.exon_index;
      cmd_new.coord_a = (req_tuser == flf_pkg::OP_QUERY) ? req_fields.position
                                                          : req_fields.exon_start;
      cmd_new.coord_b = req_fields.exon_end;
   end

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + flf_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + flf_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + flf_pkg::QUEUE_CNT_W'(push)
                           - flf_pkg::QUEUE_CNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign q_valid = count_ff != '0;
   assign q_cmd   = queue_ff[rd_ptr_ff];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= flf_pkg::QUEUE_DEPTH)
      else $error("front queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != '0)
      else $error("front queue popped while empty");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> count_ff == '0 && wr_ptr_ff == rd_ptr_ff)
      else $error("front queue not empty after reset");

endmodule

### hw/rtl/flf_engine.sv
// ----------------------------------------------------------------------------
// Spliced flank locator engine
// Holds the exon tables, scans for the exon of a position, walks backward and
// forward for the flank bounds and keeps the result register.
// ----------------------------------------------------------------------------
module flf_engine #(
   parameter int MAX_EXONS = flf_pkg::MAX_EXONS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  flf_pkg::cfg_type    cfg,
   input  logic                q_valid,
   input  flf_pkg::cmd_type    q_cmd,
   output logic                q_pop,
   output logic                rsp_valid,
   output flf_pkg::res_type    rsp_res,
   input  logic                rsp_ready
);

   localparam int AW    = (MAX_EXONS > 1) ? $clog2(MAX_EXONS) : 1;
   localparam int CW    = $clog2(MAX_EXONS + 1);
   localparam int ACC_W = $clog2(MAX_EXONS) + 34;

   logic [flf_pkg::COORD_W-1:0]  start_mem [MAX_EXONS];
   logic [flf_pkg::COORD_W-1:0]  end_mem   [MAX_EXONS];

   flf_pkg::eng_state_type       state_ff, state_in;
   logic [AW-1:0]                idx_ff, idx_in;
   logic [AW-1:0]                found_idx_ff, found_idx_in;
   logic signed [ACC_W-1:0]      bases_ff, bases_in;
   logic [flf_pkg::COORD_W-1:0]  pos_ff, pos_in;
   flf_pkg::res_type             res_ff, res_in;
   logic                         out_valid_ff, out_valid_in;
   flf_pkg::res_type             out_res_ff, out_res_in;
   logic [flf_pkg::COORD_W-1:0]  rd_start_ff, rd_end_ff;
   logic                         mem_we;
   logic [AW-1:0]                wr_addr;

   logic [CW-1:0]                n_cnt;
   logic [CW-1:0]                idx_ext;
   logic                         is_first, scan_last, back_last;
   logic                         below_start, within_end;
   logic [flf_pkg::COORD_W-1:0]  edge_sel, hi_sel, lo_sel;
   logic signed [ACC_W-1:0]      avail, need, target;
   logic                         enough;
   logic [flf_pkg::COORD_W-1:0]  sat_val;
   flf_pkg::res_type             miss_res;

   // Active entry count, capped at the table size
   assign n_cnt = (32'(cfg.exon_count) > MAX_EXONS) ? CW'(MAX_EXONS)
                                                   : CW'(cfg.exon_count);

   assign idx_ext     = CW'(idx_ff);
   assign scan_last   = (idx_ext + CW'(1)) == n_cnt;
   assign back_last   = idx_ff == '0;
   assign is_first    = idx_ff == found_idx_ff;
   assign below_start = pos_ff < rd_start_ff;
   assign within_end  = pos_ff <= rd_end_ff;

   // Shared walk step: available bases against bases still needed
   always_comb begin
      if (state_ff == flf_pkg::ST_BACK) begin
         edge_sel = is_first ? pos_ff : rd_end_ff;
         hi_sel   = edge_sel;
         lo_sel   = rd_start_ff;
      end else begin
         edge_sel = is_first ? pos_ff : rd_start_ff;
         hi_sel   = rd_end_ff;
         lo_sel   = edge_sel;
      end
      avail  = $signed(ACC_W'(hi_sel)) - $signed(ACC_W'(lo_sel));
      need   = $signed(ACC_W'(cfg.flank_size)) - bases_ff;
      enough = avail >= need;
      target = (state_ff == flf_pkg::ST_BACK) ? $signed(ACC_W'(edge_sel)) - need
                                              : $signed(ACC_W'(edge_sel)) + need;
      if (target[ACC_W-1]) begin
         sat_val = '0;
      end else if (|target[ACC_W-2:flf_pkg::COORD_W]) begin
         sat_val = '1;
      end else begin
         sat_val = target[flf_pkg::COORD_W-1:0];
      end
   end

   always_comb begin
      miss_res.status      = flf_pkg::STATUS_MISS;
      miss_res.exon_number = '0;
      miss_res.flank_start = '0;
      miss_res.flank_end   = '0;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         flf_pkg::ST_IDLE: begin
            if (q_valid && q_cmd.kind == flf_pkg::CMD_QUERY) begin
               state_in = (n_cnt == '0) ? flf_pkg::ST_EMIT : flf_pkg::ST_SCAN;
            end
         end
         flf_pkg::ST_SCAN: begin
            if (below_start) begin
               state_in = flf_pkg::ST_EMIT;
            end else if (within_end) begin
               state_in = (pos_ff == '0 || cfg.flank_size == '0) ? flf_pkg::ST_EMIT
                                                                 : flf_pkg::ST_BACK;
            end else if (scan_last) begin
               state_in = flf_pkg::ST_EMIT;
            end
         end
         flf_pkg::ST_BACK: begin
            if (enough || back_last) begin
               state_in = flf_pkg::ST_FWD;
            end
         end
         flf_pkg::ST_FWD: begin
            if (enough || scan_last) begin
               state_in = flf_pkg::ST_EMIT;
            end
         end
         flf_pkg::ST_EMIT: begin
            if (!out_valid_ff || rsp_ready) begin
               state_in = flf_pkg::ST_IDLE;
            end
         end
         default: state_in = flf_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      wr_addr      = AW'(q_cmd.index);
      idx_in       = idx_ff;
      found_idx_in = found_idx_ff;
      bases_in     = bases_ff;
      pos_in       = pos_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_res_in   = out_res_ff;
      unique case (state_ff)
         flf_pkg::ST_IDLE: begin
            idx_in = '0;
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_cmd.kind == flf_pkg::CMD_LOAD) begin
                  mem_we = 1'b1;
               end else begin
                  pos_in = q_cmd.coord_a;
                  res_in = miss_res;
               end
            end
         end
         flf_pkg::ST_SCAN: begin
            if (!below_start && within_end) begin
               res_in.status      = flf_pkg::STATUS_FOUND;
               res_in.exon_number = flf_pkg::NUM_W'(idx_ext + CW'(1));
               found_idx_in       = idx_ff;
               bases_in           = '0;
               if (pos_ff == '0) begin
                  res_in.flank_start = '0;
                  res_in.flank_end   = '0;
               end else if (cfg.flank_size == '0) begin
                  res_in.flank_start = pos_ff;
                  res_in.flank_end   = pos_ff;
               end
            end else if (!below_start && !scan_last) begin
               idx_in = idx_ff + AW'(1);
            end
         end
         flf_pkg::ST_BACK: begin
            if (enough) begin
               res_in.flank_start = sat_val;
               idx_in             = found_idx_ff;
               bases_in           = '0;
            end else if (back_last) begin
               // ran off the first exon: clamp to the gene start
               res_in.flank_start = rd_start_ff;
               idx_in             = found_idx_ff;
               bases_in           = '0;
            end else begin
               bases_in = bases_ff + avail;
               idx_in   = idx_ff - AW'(1);
            end
         end
         flf_pkg::ST_FWD: begin
            if (enough) begin
               res_in.flank_end = sat_val;
            end else if (scan_last) begin
               // ran off the last exon: clamp to the gene end
               res_in.flank_end = rd_end_ff;
            end else begin
               bases_in = bases_ff + avail;
               idx_in   = idx_ff + AW'(1);
            end
         end
         flf_pkg::ST_EMIT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_res_in   = res_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= flf_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      found_idx_ff <= found_idx_in;
      bases_ff     <= bases_in;
      pos_ff       <= pos_in;
      res_ff       <= res_in;
      out_res_ff   <= out_res_in;
   end

   // Exon tables, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         start_mem[wr_addr] <= q_cmd.coord_a;
         end_mem[wr_addr]   <= q_cmd.coord_b;
      end
      rd_start_ff <= start_mem[idx_in];
      rd_end_ff   <= end_mem[idx_in];
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_res   = out_res_ff;

   a_miss_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_res.status == flf_pkg::STATUS_MISS) |->
      (rsp_res.exon_number == '0 && rsp_res.flank_start == '0 &&
       rsp_res.flank_end == '0))
      else $error("miss result carries nonzero fields");

   a_found_number: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_res.status == flf_pkg::STATUS_FOUND) |->
      rsp_res.exon_number != '0)
      else $error("found result without exon number");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == flf_pkg::ST_SCAN || state_ff == flf_pkg::ST_BACK ||
       state_ff == flf_pkg::ST_FWD) |-> idx_ext < n_cnt)
      else $error("walk index beyond active exon count");

   a_fwd_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == flf_pkg::ST_FWD && $past(state_ff) == flf_pkg::ST_BACK) |->
      (idx_ff == found_idx_ff && bases_ff == '0))
      else $error("forward walk did not restart at the found exon");

endmodule

### dv/flank_bound_check.sv
// ----------------------------------------------------------------------------
// Spliced flank bound checker
// Watches the request, result and register channels of the spliced flank
// locator, keeps its own exon table and settings, works out the bounds that
// every query must return and compares each result, in order, field by field.
// ----------------------------------------------------------------------------
module flank_bound_check
   import flf_pkg::*;
#(
   parameter int MAX_EXONS = MAX_EXONS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint COORD_TOP = 64'h7FFF_FFFF;

   logic [COORD_W-1:0] exon_lo [MAX_EXONS];
   logic [COORD_W-1:0] exon_hi [MAX_EXONS];
   logic [FLANK_W-1:0] flank_want;
   logic [COUNT_W-1:0] exon_total;

   res_type bounds_due[$];
   int      mismatch_count = 0;
   int      due_count = 0;

   assign fail_count    = mismatch_count;
   assign pending_count = due_count;

   initial begin
      for (int i = 0; i < MAX_EXONS; i++) begin
         exon_lo[i] = '0;
         exon_hi[i] = '0;
      end
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns flank check: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic longint clamp_coord(input longint v);
      if (v < 0) return 0;
      if (v > COORD_TOP) return COORD_TOP;
      return v;
   endfunction

   // Scan for the holding exon, then gather flank_want bases each way.
   function automatic res_type locate_flanks(input logic [COORD_W-1:0] pos);
      res_type r;
      int      n;
      int      hit;
      int      k;
      longint  p;
      longint  gathered;
      longint  need;
      longint  room;
      longint  brink;
      longint  fs;
      longint  fe;
      n   = (exon_total > MAX_EXONS) ? MAX_EXONS : int'(exon_total);
      hit = 0;
      p   = longint'(pos);
      r   = '0;
      for (int i = 0; i < n; i++) begin
         if (p < longint'(exon_lo[i])) break;
         if (p <= longint'(exon_hi[i])) begin
            hit = i + 1;
            break;
         end
      end
      if (hit == 0) begin
         r.status = STATUS_MISS;
         return r;
      end
      if (p == 0) begin
         fs = 0;
         fe = 0;
      end else if (flank_want == '0) begin
         fs = p;
         fe = p;
      end else begin
         // upstream: run off the table and the gene's first start stands
         fs       = longint'(exon_lo[0]);
         gathered = 0;
         for (k = hit; k >= 1; k--) begin
            brink = (k == hit) ? p : longint'(exon_hi[k-1]);
            need  = longint'(flank_want) - gathered;
            room  = brink - longint'(exon_lo[k-1]);
            if (room >= need) begin
               fs = clamp_coord(brink - need);
               break;
            end
            gathered += room;
         end
         // downstream: likewise, falling back to the gene's last end
         fe       = longint'(exon_hi[n-1]);
         gathered = 0;
         for (k = hit; k <= n; k++) begin
            brink = (k == hit) ? p : longint'(exon_lo[k-1]);
            need  = longint'(flank_want) - gathered;
            room  = longint'(exon_hi[k-1]) - brink;
            if (room >= need) begin
               fe = clamp_coord(brink + need);
               break;
            end
            gathered += room;
         end
      end
      r.status      = STATUS_FOUND;
      r.exon_number = NUM_W'(hit);
      r.flank_start = fs[COORD_W-1:0];
      r.flank_end   = fe[COORD_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      req_payload_type rq;
      rsp_payload_type rs;
      res_type         want;
      if (reset) begin
         flank_want = FLANK_RESET;
         exon_total = COUNT_RESET;
         bounds_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FLANK_SIZE: flank_want = csr_data;
               CSR_EXON_COUNT: exon_total = csr_data[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            rs = rsp_payload_type'(rsp_tdata);
            if (bounds_due.size() == 0) begin
               report_mismatch("result arrived with no query outstanding");
            end else begin
               want = bounds_due.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch($sformatf("status got %0b want %0b",
                                            rsp_tuser, want.status));
               if (rs.exon_number !== want.exon_number)
                  report_mismatch($sformatf("exon_number got %0d want %0d",
                                            rs.exon_number, want.exon_number));
               if (rs.flank_start !== want.flank_start)
                  report_mismatch($sformatf("flank_start got %0d want %0d",
                                            rs.flank_start, want.flank_start));
               if (rs.flank_end !== want.flank_end)
                  report_mismatch($sformatf("flank_end got %0d want %0d",
                                            rs.flank_end, want.flank_end));
            end
         end
         if (req_tvalid && req_tready) begin
            rq = req_payload_type'(req_tdata);
            if (req_tuser == OP_LOAD) begin
               if (int'(rq.exon_index) < MAX_EXONS) begin
                  exon_lo[rq.exon_index] = rq.exon_start;
                  exon_hi[rq.exon_index] = rq.exon_end;
               end
            end else begin
               bounds_due.push_back(locate_flanks(rq.position));
            end
         end
      end
      due_count <= bounds_due.size();
   end

endmodule

### dv/tb_spliced_flank_locator.sv
// ----------------------------------------------------------------------------
// Spliced flank locator testbench
// Loads exon tables, sets flank size and exon count between phases and fires
// query positions at the block, with random idling on both stream sides. A
// separate checker predicts every result and counts mismatches; this module
// makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_spliced_flank_locator;
   import flf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          MAX_EXONS    = MAX_EXONS_DEF;
   localparam int unsigned COORD_MAX    = 32'h7FFF_FFFF;
   localparam int          RANDOM_ITEMS = 40;
   // loads in the front queue may still be landing once the last result is in
   localparam int          SETTLE_CYCLES = 24;
   // an index past both registers, which the block must ignore
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 8'hFF;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   int flank_faults;
   int bounds_waiting;

   // Stimulus copy of the gene, used only to aim query positions
   int unsigned gene_lo [MAX_EXONS];
   int unsigned gene_hi [MAX_EXONS];
   int          items_sent  = 0;
   bit          sender_calm = 1'b0;

   spliced_flank_locator #(.MAX_EXONS(MAX_EXONS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   flank_bound_check #(.MAX_EXONS(MAX_EXONS)) flank_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (flank_faults),
      .pending_count (bounds_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop, far beyond the slowest legal run
   initial begin
      #20ms;
      $display("** spliced_flank_locator: FAILED **");
      $finish;
   end

   // Result side back-pressure: ready runs broken by stalls, mostly short,
   // now and then a long one, and every so often a long stall-free stretch.
   initial begin : rsp_sink
      int run;
      int stall;
      forever begin
         run   = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 400)
                                             : $urandom_range(1, 12);
         stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                             : $urandom_range(1, 3);
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
         rsp_tready <= 1'b0;
         repeat (stall) @(posedge clock);
      end
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 31);
      if (sender_calm || r < 16) return 0;
      if (r < 28) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Present one item and hold it until accepted. Enter and leave on a rising
   // edge; valid is only dropped when a gap really follows, so it never sees
   // two assignments in one step.
   task automatic send_item(input logic op, input int unsigned idx,
                            input int unsigned lo, input int unsigned hi,
                            input int unsigned pos);
      req_payload_type pl;
      int              gap;
      pl            = '0;
      pl.exon_index = idx[INDEX_W-1:0];
      pl.exon_start = lo[COORD_W-1:0];
      pl.exon_end   = hi[COORD_W-1:0];
      pl.position   = pos[COORD_W-1:0];
      gap           = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(pl);
      req_tuser  <= op;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      items_sent++;
   endtask

   // Write one exon; the unused position field carries noise
   task automatic put_exon(input int unsigned idx, input int unsigned lo,
                           input int unsigned hi);
      gene_lo[idx] = lo;
      gene_hi[idx] = hi;
      send_item(OP_LOAD, idx, lo, hi, $urandom());
   endtask

   // Query a position; the unused load fields carry noise
   task automatic query_at(input int unsigned pos);
      send_item(OP_QUERY, $urandom(), $urandom(), $urandom(), pos);
   endtask

   // Hold the sender until every query has answered and queued loads landed
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (bounds_waiting != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly inside an exon, otherwise around the gene's ends or anywhere
   function automatic int unsigned pick_position(input int n);
      int          e;
      int unsigned a;
      int unsigned b;
      e = $urandom_range(0, n - 1);
      a = (gene_lo[0] >= 5) ? gene_lo[0] - 5 : 0;
      b = (gene_hi[n-1] <= COORD_MAX - 5) ? gene_hi[n-1] + 5 : COORD_MAX;
      case ($urandom_range(0, 9))
         0:       return $urandom() & COORD_MAX;
         1:       return ($urandom_range(0, 1) != 0) ? COORD_MAX : 0;
         2, 3:    return $urandom_range(a, b);
         default: return (gene_lo[e] <= gene_hi[e]) ?
                         $urandom_range(gene_lo[e], gene_hi[e]) : gene_lo[e];
      endcase
   endfunction

   // One random gene: new settings, a fresh small table, then a query burst
   task automatic random_phase();
      int          n;
      int          mode;
      int unsigned cursor;
      int unsigned lo;
      int unsigned hi;
      wait_drained();
      sender_calm = ($urandom_range(0, 3) == 0);
      n           = $urandom_range(1, 12);
      case ($urandom_range(0, 7))
         0:       csr_write(CSR_FLANK_SIZE, '0);
         1:       csr_write(CSR_FLANK_SIZE, '1);
         2:       csr_write(CSR_FLANK_SIZE, CSR_DATA_W'($urandom_range(0, 16'hFFFF)));
         default: csr_write(CSR_FLANK_SIZE, CSR_DATA_W'($urandom_range(1, 80)));
      endcase
      csr_write(CSR_EXON_COUNT, CSR_DATA_W'(n));
      // gene at coordinate zero, at the top of the range, or anywhere
      mode   = $urandom_range(0, 3);
      cursor = (mode == 0) ? 0 :
               (mode == 1) ? COORD_MAX - 1000 : $urandom_range(0, COORD_MAX - 1000);
      for (int i = 0; i < n; i++) begin
         lo = cursor + $urandom_range(0, 20);
         hi = lo + $urandom_range(0, 60);
         cursor = hi;
         // now and then an exon whose start lies above its end
         if ($urandom_range(0, 11) == 0 && lo > 0)
            hi = lo - $urandom_range(1, (lo < 10) ? lo : 10);
         gene_lo[i] = lo;
         gene_hi[i] = hi;
      end
      if (mode == 1) gene_hi[n-1] = COORD_MAX;
      if ($urandom_range(0, 1) != 0) begin
         for (int i = 0; i < n; i++) put_exon(i, gene_lo[i], gene_hi[i]);
      end else begin
         for (int i = n - 1; i >= 0; i--) put_exon(i, gene_lo[i], gene_hi[i]);
      end
      repeat ($urandom_range(8, 30)) begin
         if ($urandom_range(0, 9) == 0)
            put_exon($urandom_range(0, MAX_EXONS - 1),
                     $urandom() & COORD_MAX, $urandom() & COORD_MAX);
         else
            query_at(pick_position(n));
         if ($urandom_range(0, 39) == 0) wait_drained();
      end
   endtask

   // Every slot loaded, count written past the table so all of it is in use
   task automatic full_table_phase();
      int unsigned cursor;
      wait_drained();
      sender_calm = 1'b0;
      csr_write(CSR_FLANK_SIZE, CSR_DATA_W'($urandom_range(1000, 16'hFFFF)));
      csr_write(CSR_EXON_COUNT, '1);
      cursor = $urandom_range(0, COORD_MAX - 4_000_000);
      for (int i = 0; i < MAX_EXONS; i++) begin
         gene_lo[i] = cursor + $urandom_range(1, 500);
         gene_hi[i] = gene_lo[i] + $urandom_range(0, 5000);
         cursor     = gene_hi[i];
      end
      for (int i = MAX_EXONS - 1; i >= 0; i--) put_exon(i, gene_lo[i], gene_hi[i]);
      repeat (20) query_at(pick_position(MAX_EXONS));
   endtask

   initial begin : stimulus
      int directed_items;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings (flank 20, one exon): miss before, both edges, inside,
      // miss just past the end.
      put_exon(0, 1000, 2000);
      query_at(999);
      query_at(1000);
      query_at(1500);
      query_at(2000);
      query_at(2001);

      // Flank zero over three exons, the last one running to the top
      // coordinate; a write to an unknown index must change nothing.
      wait_drained();
      csr_write(CSR_FLANK_SIZE, '0);
      csr_write(CSR_EXON_COUNT, CSR_DATA_W'(3));
      csr_write(CSR_SPARE, '1);
      put_exon(0, 0, 10);
      put_exon(1, 20, 30);
      put_exon(2, 40, COORD_MAX);
      put_exon(3, COORD_MAX, 0);
      query_at(0);
      query_at(5);
      query_at(15);
      query_at(COORD_MAX);

      // Widest flank: upstream walk runs off the gene; position zero still 0
      wait_drained();
      csr_write(CSR_FLANK_SIZE, '1);
      query_at(0);
      query_at(25);

      // No exons in use: everything misses
      wait_drained();
      csr_write(CSR_EXON_COUNT, '0);
      query_at(5);

      // Malformed first exon ahead of a good one
      wait_drained();
      csr_write(CSR_FLANK_SIZE, CSR_DATA_W'(60));
      csr_write(CSR_EXON_COUNT, CSR_DATA_W'(2));
      put_exon(0, 5, 2);
      put_exon(1, 3, 100);
      query_at(50);
      query_at(2);

      directed_items = items_sent;
      while (items_sent - directed_items < RANDOM_ITEMS) random_phase();
      full_table_phase();

      // Drain, then give a stray result the chance to show up
      req_tvalid <= 1'b0;
      for (int c = 0; c < 200000 && bounds_waiting != 0; c++) @(negedge clock);
      repeat (64) @(posedge clock);
      if (flank_faults == 0 && bounds_waiting == 0) begin
         $display("** spliced_flank_locator: PASSED **");
      end else begin
         $display("** spliced_flank_locator: FAILED **");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/flf_pkg.sv
hw/rtl/flf_front.sv
hw/rtl/flf_engine.sv
hw/rtl/spliced_flank_locator.sv
dv/flank_bound_check.sv
dv/tb_spliced_flank_locator.sv
